FILE: rtl/cf2slcan_pkg.sv
// ----------------------------------------------------------------------------
// cf2slcan_pkg
// Shared types, constants and helpers of the CAN frame to SLCAN line encoder.
// ----------------------------------------------------------------------------
package cf2slcan_pkg;

  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned MaxBytes     = 8;

  localparam logic [CfgIdxW-1:0] CFG_CHANNEL_OPEN  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIMESTAMP_EN  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LINE_FEED_EN  = 2'd2;

  localparam logic [7:0] ChExtData = 8'h54;  // T
  localparam logic [7:0] ChExtRtr  = 8'h52;  // R
  localparam logic [7:0] ChStdData = 8'h74;  // t
  localparam logic [7:0] ChStdRtr  = 8'h72;  // r
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChLf      = 8'h0A;

  typedef struct packed {
    logic [7:0]  prefix;
    logic        extended;
    logic [28:0] identifier;
    logic [3:0]  length;
    logic [3:0]  nbytes;
    logic [63:0] payload;
    logic [15:0] time_ms;
    logic        ts_en;
    logic        lf_en;
  } frame_desc_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD,
    ST_ID,
    ST_LEN,
    ST_DATA,
    ST_TIME,
    ST_CR,
    ST_CR2,
    ST_LF
  } back_state_e;

  // upper-case hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'b0000, nib};
    end else begin
      ch = 8'h37 + {4'b0000, nib};
    end
    return ch;
  endfunction

endpackage

FILE: rtl/cf2slcan_front.sv
// ----------------------------------------------------------------------------
// cf2slcan_front
// Holds the configuration, accepts frames, drops them while the channel is
// closed and builds the line descriptor pushed into the queue.
// ----------------------------------------------------------------------------
module cf2slcan_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cf2slcan_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [0:0]                          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                extended_i,
  input  logic                                remote_i,
  input  logic [28:0]                         identifier_i,
  input  logic [3:0]                          length_i,
  input  logic [63:0]                         payload_i,
  input  logic [15:0]                         time_ms_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output cf2slcan_pkg::frame_desc_t           desc_o
);

  logic open_q, open_d;
  logic ts_q, ts_d;
  logic lf_q, lf_d;

  always_comb begin
    open_d = open_q;
    ts_d   = ts_q;
    lf_d   = lf_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        cf2slcan_pkg::CFG_CHANNEL_OPEN: open_d = cfg_data_i[0];
        cf2slcan_pkg::CFG_TIMESTAMP_EN: ts_d   = cfg_data_i[0];
        cf2slcan_pkg::CFG_LINE_FEED_EN: lf_d   = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      ts_q   <= 1'b0;
      lf_q   <= 1'b0;
    end else begin
      open_q <= open_d;
      ts_q   <= ts_d;
      lf_q   <= lf_d;
    end
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && open_q;

  always_comb begin
    case ({extended_i, remote_i})
      2'b11:   desc_o.prefix = cf2slcan_pkg::ChExtRtr;
      2'b10:   desc_o.prefix = cf2slcan_pkg::ChExtData;
      2'b01:   desc_o.prefix = cf2slcan_pkg::ChStdRtr;
      default: desc_o.prefix = cf2slcan_pkg::ChStdData;
    endcase
    desc_o.extended   = extended_i;
    desc_o.identifier = identifier_i;
    desc_o.length     = length_i;
    desc_o.nbytes     = (length_i > 4'(cf2slcan_pkg::MaxBytes)) ?
                        4'(cf2slcan_pkg::MaxBytes) : length_i;
    desc_o.payload    = payload_i;
    desc_o.time_ms    = time_ms_i;
    desc_o.ts_en      = ts_q;
    desc_o.lf_en      = lf_q;
  end

endmodule

FILE: rtl/cf2slcan_queue.sv
// ----------------------------------------------------------------------------
// cf2slcan_queue
// Short descriptor queue between the front and the line sequencer.
// ----------------------------------------------------------------------------
module cf2slcan_queue #(
  parameter int unsigned Depth = cf2slcan_pkg::QueueDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  cf2slcan_pkg::frame_desc_t wr_data_i,
  output logic                      full_o,
  input  logic                      pop_i,
  output logic                      rd_valid_o,
  output cf2slcan_pkg::frame_desc_t rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cf2slcan_pkg::frame_desc_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o     = (cnt_q == CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? ptr_inc(wptr_q) : wptr_q;
    rptr_d = pop_i ? ptr_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: rtl/cf2slcan_back.sv
// ----------------------------------------------------------------------------
// cf2slcan_back
// Line sequencer: walks one descriptor and emits its characters, one per
// cycle while the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module cf2slcan_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_valid_i,
  input  cf2slcan_pkg::frame_desc_t rd_data_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                character_o,
  output logic                      last_o
);

  cf2slcan_pkg::back_state_e state_q, state_d;
  cf2slcan_pkg::frame_desc_t desc_q;
  logic [3:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] char_q;
  logic       last_q;

  logic [31:0] id32;
  logic [3:0]  nib;
  logic [3:0]  stop;
  logic [7:0]  char_c;
  logic        last_c;
  logic        done_c;
  logic        adv;
  logic        emit;

  assign id32 = {3'b000, desc_q.identifier};
  assign stop = 4'(5'd16 - {desc_q.nbytes, 1'b0});
  assign adv  = !out_valid_q || !out_stall_i;
  assign emit = (state_q != cf2slcan_pkg::ST_IDLE) && adv;

  // character of the current position
  always_comb begin
    nib    = '0;
    char_c = '0;
    last_c = 1'b0;
    done_c = 1'b0;
    case (state_q)
      cf2slcan_pkg::ST_HEAD: begin
        char_c = desc_q.prefix;
      end
      cf2slcan_pkg::ST_ID: begin
        nib    = id32[{cnt_q[2:0], 2'b00} +: 4];
        char_c = cf2slcan_pkg::hex_char(nib);
        done_c = (cnt_q == 4'd0);
      end
      cf2slcan_pkg::ST_LEN: begin
        nib    = desc_q.length;
        char_c = cf2slcan_pkg::hex_char(nib);
      end
      cf2slcan_pkg::ST_DATA: begin
        nib    = desc_q.payload[{cnt_q, 2'b00} +: 4];
        char_c = cf2slcan_pkg::hex_char(nib);
        done_c = (cnt_q == stop);
      end
      cf2slcan_pkg::ST_TIME: begin
        nib    = desc_q.time_ms[{cnt_q[1:0], 2'b00} +: 4];
        char_c = cf2slcan_pkg::hex_char(nib);
        done_c = (cnt_q == 4'd0);
      end
      cf2slcan_pkg::ST_CR: begin
        char_c = cf2slcan_pkg::ChCr;
        last_c = !desc_q.lf_en;
      end
      cf2slcan_pkg::ST_CR2: begin
        char_c = cf2slcan_pkg::ChCr;
      end
      cf2slcan_pkg::ST_LF: begin
        char_c = cf2slcan_pkg::ChLf;
        last_c = 1'b1;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pop_o   = 1'b0;
    case (state_q)
      cf2slcan_pkg::ST_IDLE: begin
        if (rd_valid_i) begin
          pop_o   = 1'b1;
          state_d = cf2slcan_pkg::ST_HEAD;
        end
      end
      cf2slcan_pkg::ST_HEAD: begin
        if (emit) begin
          state_d = cf2slcan_pkg::ST_ID;
          cnt_d   = desc_q.extended ? 4'd7 : 4'd2;
        end
      end
      cf2slcan_pkg::ST_ID: begin
        if (emit) begin
          if (done_c) begin
            state_d = cf2slcan_pkg::ST_LEN;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      cf2slcan_pkg::ST_LEN: begin
        if (emit) begin
          if (desc_q.nbytes != 4'd0) begin
            state_d = cf2slcan_pkg::ST_DATA;
            cnt_d   = 4'd15;
          end else if (desc_q.ts_en) begin
            state_d = cf2slcan_pkg::ST_TIME;
            cnt_d   = 4'd3;
          end else begin
            state_d = cf2slcan_pkg::ST_CR;
          end
        end
      end
      cf2slcan_pkg::ST_DATA: begin
        if (emit) begin
          if (!done_c) begin
            cnt_d = cnt_q - 1'b1;
          end else if (desc_q.ts_en) begin
            state_d = cf2slcan_pkg::ST_TIME;
            cnt_d   = 4'd3;
          end else begin
            state_d = cf2slcan_pkg::ST_CR;
          end
        end
      end
      cf2slcan_pkg::ST_TIME: begin
        if (emit) begin
          if (done_c) begin
            state_d = cf2slcan_pkg::ST_CR;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      cf2slcan_pkg::ST_CR: begin
        if (emit) begin
          state_d = desc_q.lf_en ? cf2slcan_pkg::ST_CR2 : cf2slcan_pkg::ST_IDLE;
        end
      end
      cf2slcan_pkg::ST_CR2: begin
        if (emit) begin
          state_d = cf2slcan_pkg::ST_LF;
        end
      end
      cf2slcan_pkg::ST_LF: begin
        if (emit) begin
          state_d = cf2slcan_pkg::ST_IDLE;
        end
      end
      default: state_d = cf2slcan_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (adv) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cf2slcan_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      desc_q <= rd_data_i;
    end
    if (emit) begin
      char_q <= char_c;
      last_q <= last_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

FILE: rtl/can_frame_to_slcan_ascii.sv
// ----------------------------------------------------------------------------
// can_frame_to_slcan_ascii
// Encodes one received CAN frame into its SLCAN text line, one character
// per output beat.
//
//   Channel  Dir  Handshake                Payload
//   in       in   in_valid_i / in_stall_o  extended, remote, identifier,
//                                          length, payload, time_ms
//   out      out  out_valid_o/ out_stall_i character, last
//   cfg      in   cfg_we_i                 cfg_idx_i, cfg_data_i
//
// A line is 6 to 33 characters, one per cycle while the output is not
// stalled; the sequencer passes through its idle state to load the next frame.
// Frames queue up to QueueDepth deep while a line is being sent.
// Reset clears the configuration (channel closed), the queue and the
// sequencer. Output stall holds the current character; the input stalls
// only when the queue is full. Frames taken while closed are dropped.
// ----------------------------------------------------------------------------
module can_frame_to_slcan_ascii #(
  parameter int unsigned QueueDepth = cf2slcan_pkg::QueueDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cf2slcan_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [0:0]                       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             extended_i,
  input  logic                             remote_i,
  input  logic [28:0]                      identifier_i,
  input  logic [3:0]                       length_i,
  input  logic [63:0]                      payload_i,
  input  logic [15:0]                      time_ms_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       character_o,
  output logic                             last_o
);

  logic                      q_full;
  logic                      push;
  logic                      pop;
  logic                      rd_valid;
  cf2slcan_pkg::frame_desc_t wr_desc;
  cf2slcan_pkg::frame_desc_t rd_desc;

  cf2slcan_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .extended_i  (extended_i),
    .remote_i    (remote_i),
    .identifier_i(identifier_i),
    .length_i    (length_i),
    .payload_i   (payload_i),
    .time_ms_i   (time_ms_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .desc_o      (wr_desc)
  );

  cf2slcan_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (wr_desc),
    .full_o    (q_full),
    .pop_i     (pop),
    .rd_valid_o(rd_valid),
    .rd_data_o (rd_desc)
  );

  cf2slcan_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_valid_i (rd_valid),
    .rd_data_i  (rd_desc),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

endmodule

FILE: rtl/cf2slcan_checker.sv
// ----------------------------------------------------------------------------
// cf2slcan_checker
// Port-level checks of the SLCAN line encoder, bound to the top level.
// ----------------------------------------------------------------------------
module cf2slcan_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] character_o,
  input logic       last_o
);

  // a stalled beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // a line streams without gaps until its last character
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("gap inside a line");

  // the last character is CR or LF
  a_last_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |->
      character_o == cf2slcan_pkg::ChCr || character_o == cf2slcan_pkg::ChLf)
    else $error("line ends with a non-terminator");

  // LF only closes a line
  a_lf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && character_o == cf2slcan_pkg::ChLf |-> last_o)
    else $error("line feed not marked last");

endmodule

bind can_frame_to_slcan_ascii cf2slcan_checker u_cf2slcan_checker (.*);

FILE: verif/slcan_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcan_line_checker
// Watches the frame, character and register ports of the SLCAN encoder.
// Keeps its own copy of the registers, turns every frame accepted while open
// into the characters of its text line, and compares each character beat in order.
// ----------------------------------------------------------------------------
module slcan_line_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cf2slcan_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [0:0]                       cfg_data_i,
  input  logic                             frm_valid_i,
  input  logic                             frm_stall_i,
  input  logic                             ext_i,
  input  logic                             rtr_i,
  input  logic [28:0]                      id_i,
  input  logic [3:0]                       len_i,
  input  logic [63:0]                      data_i,
  input  logic [15:0]                      ms_i,
  input  logic                             chr_valid_i,
  input  logic                             chr_stall_i,
  input  logic [7:0]                       chr_i,
  input  logic                             chr_last_i,
  output int                               err_cnt_o,
  output int                               pending_o,
  output int                               frames_o,
  output int                               dropped_o,
  output int                               chars_o
);

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } line_char_t;

  line_char_t line_q[$];
  logic       chan_open;
  logic       ts_en;
  logic       lf_en;
  int         errors;
  int         n_frames;
  int         n_dropped;
  int         n_chars;

  task automatic report_bad(input string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic logic [7:0] nib_ascii(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = 8'h30 + 8'(v);
    end else begin
      c = 8'h41 + 8'(v) - 8'd10;
    end
    return c;
  endfunction

  function automatic void put_char(input logic [7:0] c, input logic is_last);
    line_char_t e;
    e.chr  = c;
    e.last = is_last;
    line_q.push_back(e);
  endfunction

  function automatic void encode_line(input logic ext, input logic rtr,
                                      input logic [28:0] id, input logic [3:0] len,
                                      input logic [63:0] data, input logic [15:0] ms);
    logic [31:0] id_word;
    logic [7:0]  b;
    int          n_digits;
    int          n_bytes;
    int          k;
    id_word = {3'b000, id};
    if (ext) begin
      put_char(rtr ? cf2slcan_pkg::ChExtRtr : cf2slcan_pkg::ChExtData, 1'b0);
      n_digits = 8;
    end else begin
      put_char(rtr ? cf2slcan_pkg::ChStdRtr : cf2slcan_pkg::ChStdData, 1'b0);
      n_digits = 3;
    end
    for (k = n_digits - 1; k >= 0; k--) begin
      put_char(nib_ascii(id_word[4*k +: 4]), 1'b0);
    end
    put_char(nib_ascii(len), 1'b0);
    n_bytes = (len > 4'd8) ? 8 : int'(len);
    for (k = 0; k < n_bytes; k++) begin
      b = data[63 - 8*k -: 8];
      put_char(nib_ascii(b[7:4]), 1'b0);
      put_char(nib_ascii(b[3:0]), 1'b0);
    end
    if (ts_en) begin
      for (k = 3; k >= 0; k--) begin
        put_char(nib_ascii(ms[4*k +: 4]), 1'b0);
      end
    end
    put_char(cf2slcan_pkg::ChCr, !lf_en);
    if (lf_en) begin
      put_char(cf2slcan_pkg::ChCr, 1'b0);
      put_char(cf2slcan_pkg::ChLf, 1'b1);
    end
  endfunction

  always @(posedge clk_i) begin
    line_char_t want;
    if (!rst_ni) begin
      chan_open = 1'b0;
      ts_en     = 1'b0;
      lf_en     = 1'b0;
      line_q.delete();
    end else begin
      // character side first: a beat can never come from a frame taken this edge
      if (chr_valid_i && !chr_stall_i) begin
        n_chars++;
        if (line_q.size() == 0) begin
          report_bad($sformatf("character %h last %b with nothing pending", chr_i, chr_last_i));
        end else begin
          want = line_q.pop_front();
          if (chr_i !== want.chr) begin
            report_bad($sformatf("character %h, want %h", chr_i, want.chr));
          end
          if (chr_last_i !== want.last) begin
            report_bad($sformatf("last %b on character %h, want %b", chr_last_i, chr_i,
                                 want.last));
          end
        end
      end
      if (frm_valid_i && !frm_stall_i) begin
        if (chan_open) begin
          n_frames++;
          encode_line(ext_i, rtr_i, id_i, len_i, data_i, ms_i);
        end else begin
          n_dropped++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cf2slcan_pkg::CFG_CHANNEL_OPEN: chan_open = cfg_data_i[0];
          cf2slcan_pkg::CFG_TIMESTAMP_EN: ts_en     = cfg_data_i[0];
          cf2slcan_pkg::CFG_LINE_FEED_EN: lf_en     = cfg_data_i[0];
          default: ;
        endcase
      end
    end
    err_cnt_o <= errors;
    pending_o <= line_q.size();
    frames_o  <= n_frames;
    dropped_o <= n_dropped;
    chars_o   <= n_chars;
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the CAN frame to SLCAN line encoder.
// Directed frames cover flag combinations, field extremes, long length codes,
// wide standard identifiers and out-of-range stamps; then random frames run
// through phases of register settings and sender/receiver idling, including
// a long receiver hold-off. Checking is done by slcan_line_checker.
// ----------------------------------------------------------------------------
module tb;

  localparam int SettleCycles = 100;
  localparam int HoldCycles   = 300;
  localparam int LimitNs      = 4_000_000;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [cf2slcan_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [0:0]                       cfg_data_i;
  logic                             in_valid_i;
  logic                             in_stall_o;
  logic                             extended_i;
  logic                             remote_i;
  logic [28:0]                      identifier_i;
  logic [3:0]                       length_i;
  logic [63:0]                      payload_i;
  logic [15:0]                      time_ms_i;
  logic                             out_valid_o;
  logic                             out_stall_i;
  logic [7:0]                       character_o;
  logic                             last_o;

  int fails;
  int pending;
  int n_frames;
  int n_dropped;
  int n_chars;
  int stall_pct;
  int idle_pct;
  bit hold_on;

  can_frame_to_slcan_ascii dut (.*);

  slcan_line_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .frm_valid_i (in_valid_i),
    .frm_stall_i (in_stall_o),
    .ext_i       (extended_i),
    .rtr_i       (remote_i),
    .id_i        (identifier_i),
    .len_i       (length_i),
    .data_i      (payload_i),
    .ms_i        (time_ms_i),
    .chr_valid_i (out_valid_o),
    .chr_stall_i (out_stall_i),
    .chr_i       (character_o),
    .chr_last_i  (last_o),
    .err_cnt_o   (fails),
    .pending_o   (pending),
    .frames_o    (n_frames),
    .dropped_o   (n_dropped),
    .chars_o     (n_chars)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stall, or held high during a hold-off
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      out_stall_i <= hold_on || ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #(LimitNs);
    $display("timeout with %0d characters still pending", pending);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_frame(input logic ext, input logic rtr, input logic [28:0] id,
                            input logic [3:0] len, input logic [63:0] data,
                            input logic [15:0] ms);
    in_valid_i   <= 1'b1;
    extended_i   <= ext;
    remote_i     <= rtr;
    identifier_i <= id;
    length_i     <= len;
    payload_i    <= data;
    time_ms_i    <= ms;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random();
    logic [3:0]  len;
    logic [15:0] ms;
    len = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8, 0));
    ms  = ($urandom_range(9) == 0) ? 16'($urandom_range(65535, 60000))
                                   : 16'($urandom_range(59999, 0));
    send_frame(1'($urandom), 1'($urandom), 29'($urandom), len,
               {$urandom, $urandom}, ms);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic open, input logic ts, input logic lf);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= cf2slcan_pkg::CFG_CHANNEL_OPEN;
    cfg_data_i <= open;
    @(posedge clk_i);
    cfg_idx_i  <= cf2slcan_pkg::CFG_TIMESTAMP_EN;
    cfg_data_i <= ts;
    @(posedge clk_i);
    cfg_idx_i  <= cf2slcan_pkg::CFG_LINE_FEED_EN;
    cfg_data_i <= lf;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic run_phase(input logic open, input logic ts, input logic lf,
                           input int snd_idle, input int rcv_stall, input int n,
                           input bit hold);
    int i;
    drain();
    set_regs(open, ts, lf);
    idle_pct = snd_idle;
    stall_pct <= rcv_stall;
    if (hold) begin
      fork
        begin
          hold_on <= 1'b1;
          repeat (HoldCycles) @(posedge clk_i);
          hold_on <= 1'b0;
        end
      join_none
    end
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < idle_pct) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(3, 1)) @(posedge clk_i);
      end
      send_random();
    end
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= cf2slcan_pkg::CFG_CHANNEL_OPEN;
    cfg_data_i   <= 1'b0;
    in_valid_i   <= 1'b0;
    extended_i   <= 1'b0;
    remote_i     <= 1'b0;
    identifier_i <= '0;
    length_i     <= '0;
    payload_i    <= '0;
    time_ms_i    <= '0;
    stall_pct    <= 0;
    idle_pct     = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // closed after reset: frames are swallowed
    send_frame(1'b0, 1'b0, 29'h123, 4'd2, 64'hDEAD_BEEF_0000_0000, 16'd5);
    send_frame(1'b1, 1'b1, 29'h1FFF_FFFF, 4'd8, '1, 16'hFFFF);
    drain();

    set_regs(1'b1, 1'b0, 1'b0);
    send_frame(1'b0, 1'b0, 29'h0, 4'd0, 64'h0, 16'h0);
    send_frame(1'b0, 1'b0, 29'h7FF, 4'd8, 64'h0123_4567_89AB_CDEF, 16'd1);
    send_frame(1'b0, 1'b1, 29'h7FF, 4'd8, '1, 16'd2);
    send_frame(1'b1, 1'b0, 29'h1FFF_FFFF, 4'd8, '1, 16'd3);
    send_frame(1'b1, 1'b1, 29'h0, 4'd0, 64'h0, 16'd4);
    send_frame(1'b1, 1'b1, 29'h1555_5555, 4'd4, 64'hA5A5_5A5A_FEDC_BA98, 16'd5);
    send_frame(1'b0, 1'b0, 29'h1ABC_DEF5, 4'd3, 64'h8001_7F00_0000_0000, 16'd6);
    send_frame(1'b0, 1'b1, 29'h0000_0800, 4'd1, 64'hFF00_0000_0000_0000, 16'd7);
    send_frame(1'b1, 1'b0, 29'h0AAA_AAAA, 4'd9, 64'h1122_3344_5566_7788, 16'd8);
    send_frame(1'b0, 1'b0, 29'h1FFF_FFFF, 4'd15, 64'h99AA_BBCC_DDEE_FF00, 16'd9);
    send_frame(1'b1, 1'b0, 29'h0000_0001, 4'd12, '1, 16'd10);
    send_frame(1'b1, 1'b1, 29'h1000_0000, 4'd7, 64'h0, 16'd11);
    drain();

    set_regs(1'b1, 1'b1, 1'b1);
    send_frame(1'b0, 1'b0, 29'h5A5, 4'd2, 64'h3C3C_0000_0000_0000, 16'd0);
    send_frame(1'b1, 1'b0, 29'h1234_5678, 4'd8, 64'h0F1E_2D3C_4B5A_6978, 16'd59999);
    send_frame(1'b0, 1'b1, 29'h001, 4'd0, 64'h0, 16'd60000);
    send_frame(1'b1, 1'b1, 29'h1FFF_FFFF, 4'd15, '1, 16'hFFFF);
    send_frame(1'b0, 1'b0, 29'h7FF, 4'd5, 64'hC0FF_EE00_1234_0000, 16'h8000);

    run_phase(1'b1, 1'b1, 1'b1, 0, 0, 40, 1'b1);
    run_phase(1'b1, 1'b0, 1'b0, 70, 0, 40, 1'b0);
    run_phase(1'b1, 1'b1, 1'b0, 0, 70, 40, 1'b0);
    run_phase(1'b1, 1'b0, 1'b1, 32, 32, 40, 1'b0);
    run_phase(1'b0, 1'b1, 1'b1, 32, 32, 20, 1'b0);
    run_phase(1'b1, 1'b1, 1'b1, 70, 70, 40, 1'b0);
    run_phase(1'b1, 1'b0, 1'b0, 0, 0, 40, 1'b0);
    run_phase(1'b1, 1'b1, 1'b0, 32, 32, 40, 1'b0);
    run_phase(1'b1, 1'b0, 1'b1, 0, 70, 40, 1'b0);
    drain();

    $display("covered %0d encoded frames, %0d dropped while closed, %0d characters checked",
             n_frames, n_dropped, n_chars);
    $display("settings: every stamp/line-feed mix, no/sender/receiver/both idling, long hold-off");
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
